@@ rtl/jpeg_coefficient_entropy_coder_top_defines.svh @@
// Assertion macros shared by the coder modules.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef JPEG_COEFFICIENT_ENTROPY_CODER_TOP_DEFINES_SVH
`define JPEG_COEFFICIENT_ENTROPY_CODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define JCEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JCEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JCEC_ASSERT(lbl, prop, msg)
`define JCEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/jcec_pkg.sv @@
`timescale 1ns / 1ps
package jcec_pkg;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int ACC_W   = 72;
  localparam int CNT_W   = 7;
  localparam int ACC_MAX = 66;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hf0;
  localparam logic [7:0] BYTE_FF = 8'hff;
  localparam logic [15:0] FLUSH_CODE = 16'h007f;
  localparam logic [4:0] FLUSH_LEN = 5'd7;

  typedef logic [7:0] cnt_arr_t [16];
  typedef logic [7:0] sym_arr_t [162];
  typedef logic [20:0] huff_tab_t [256];

  // One piece of the bit stream handed from the front end to the packer.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              flush;
  } chunk_t;

  localparam cnt_arr_t DC_LUMA_CNT = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
  localparam cnt_arr_t AC_LUMA_CNT = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,125};
  localparam cnt_arr_t DC_CHROMA_CNT = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
  localparam cnt_arr_t AC_CHROMA_CNT = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,119};

  localparam sym_arr_t DC_SYMS = '{0:0, 1:1, 2:2, 3:3, 4:4, 5:5, 6:6, 7:7, 8:8, 9:9,
                                   10:10, 11:11, default:0};

  localparam sym_arr_t AC_LUMA_SYMS = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,
    8'h15,8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
    8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,
    8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,
    8'hD9,8'hDA,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  localparam sym_arr_t AC_CHROMA_SYMS = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'hA1,8'hB1,8'hC1,8'h09,
    8'h23,8'h33,8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,
    8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8A,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,
    8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,
    8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hDA,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF2,
    8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};

  // Canonical Huffman code table indexed by symbol: {length, code}.
  // Symbols absent from the table keep length zero.
  function automatic huff_tab_t build_tab(cnt_arr_t counts, sym_arr_t syms, int nsyms);
    huff_tab_t t;
    int c;
    int k;
    for (int s = 0; s < 256; s++) begin
      t[s] = '0;
    end
    c = 0;
    k = 0;
    for (int n = 1; n <= 16; n++) begin
      for (int i = 0; i < int'(counts[n-1]); i++) begin
        if (k < nsyms) begin
          t[syms[k]] = {LEN_W'(n), CODE_W'(c)};
        end
        c++;
        k++;
      end
      c = c << 1;
    end
    return t;
  endfunction

  localparam huff_tab_t DC_LUMA_TAB   = build_tab(DC_LUMA_CNT, DC_SYMS, 12);
  localparam huff_tab_t DC_CHROMA_TAB = build_tab(DC_CHROMA_CNT, DC_SYMS, 12);
  localparam huff_tab_t AC_LUMA_TAB   = build_tab(AC_LUMA_CNT, AC_LUMA_SYMS, 162);
  localparam huff_tab_t AC_CHROMA_TAB = build_tab(AC_CHROMA_CNT, AC_CHROMA_SYMS, 162);

endpackage

@@ rtl/jcec_in_if.sv @@
`timescale 1ns / 1ps
interface jcec_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         component;
  logic signed [11:0] coefficient;

  modport source (output valid, output op, output component, output coefficient,
                  input ready);
  modport sink (input valid, input op, input component, input coefficient,
                output ready);
endinterface

@@ rtl/jcec_out_if.sv @@
`timescale 1ns / 1ps
interface jcec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/jcec_front.sv @@
`timescale 1ns / 1ps
module jcec_front import jcec_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  jcec_in_if.sink in_i,
  output chunk_t chunk_o,
  output logic   chunk_valid_o,
  input  logic   chunk_ready_i
);

  typedef enum logic {
    ST_IDLE,
    ST_PUSH
  } state_e;

  state_e             state_q, state_d;
  logic [11:0]        pred_q [3];
  logic [11:0]        pred_d [3];
  logic [5:0]         pos_q, pos_d;
  logic [5:0]         run_q, run_d;
  logic [1:0]         zrl_n_q, zrl_n_d;
  logic [20:0]        zrl_q, zrl_d;
  logic [20:0]        sym_q, sym_d;
  logic               sym_pend_q, sym_pend_d;
  logic [10:0]        mag_q, mag_d;
  logic [3:0]         mag_len_q, mag_len_d;
  logic               mag_pend_q, mag_pend_d;
  logic               flush_q, flush_d;

  logic               accept;
  logic [1:0]         pidx;
  logic               chroma;
  logic signed [11:0] coef;
  logic signed [11:0] pred;
  logic signed [12:0] diff;
  logic signed [11:0] dcv;
  logic signed [11:0] acv;
  logic signed [11:0] val;
  logic [10:0]        mag_abs;
  logic [3:0]         size;
  logic [10:0]        mask;
  logic [10:0]        mbits;
  logic [5:0]         run_inc;
  logic [7:0]         ac_sym;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign pidx   = (in_i.component == 2'd3) ? 2'd2 : in_i.component;
  assign chroma = (in_i.component != 2'd0);
  assign coef   = in_i.coefficient;
  assign pred   = pred_q[pidx];
  assign diff   = $signed({coef[11], coef}) - $signed({pred[11], pred});

  always_comb begin
    if (diff > 13'sd2047) begin
      dcv = 12'sd2047;
    end else if (diff < -13'sd2047) begin
      dcv = -12'sd2047;
    end else begin
      dcv = diff[11:0];
    end
    if (coef > 12'sd1023) begin
      acv = 12'sd1023;
    end else if (coef < -12'sd1023) begin
      acv = -12'sd1023;
    end else begin
      acv = coef;
    end
  end

  assign val     = (pos_q == 6'd0) ? dcv : acv;
  assign mag_abs = val[11] ? 11'(-val) : val[10:0];

  always_comb begin
    size = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag_abs[i]) begin
        size = 4'(i + 1);
      end
    end
  end

  assign mask    = 11'((12'd1 << size) - 12'd1);
  assign mbits   = val[11] ? (~mag_abs & mask) : mag_abs;
  assign run_inc = run_q + 6'd1;
  assign ac_sym  = {run_q[3:0], size};

  // Accept-time classification and the chunk sequencer.
  always_comb begin
    state_d    = state_q;
    pred_d     = pred_q;
    pos_d      = pos_q;
    run_d      = run_q;
    zrl_n_d    = zrl_n_q;
    zrl_d      = zrl_q;
    sym_d      = sym_q;
    sym_pend_d = sym_pend_q;
    mag_d      = mag_q;
    mag_len_d  = mag_len_q;
    mag_pend_d = mag_pend_q;
    flush_d    = flush_q;
    chunk_valid_o = 1'b0;
    chunk_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          zrl_n_d    = 2'd0;
          zrl_d      = chroma ? AC_CHROMA_TAB[SYM_ZRL] : AC_LUMA_TAB[SYM_ZRL];
          sym_pend_d = 1'b0;
          mag_pend_d = 1'b0;
          mag_d      = mbits;
          mag_len_d  = size;
          flush_d    = 1'b0;
          if (in_i.op) begin
            sym_d      = {FLUSH_LEN, FLUSH_CODE};
            sym_pend_d = 1'b1;
            flush_d    = 1'b1;
            pred_d     = '{default: '0};
            pos_d      = 6'd0;
            run_d      = 6'd0;
          end else begin
            if (pos_q == 6'd0) begin
              sym_d        = chroma ? DC_CHROMA_TAB[{4'd0, size}] : DC_LUMA_TAB[{4'd0, size}];
              sym_pend_d   = 1'b1;
              mag_pend_d   = (size != 4'd0);
              pred_d[pidx] = coef;
            end else if (coef == 12'sd0) begin
              run_d = run_inc;
              if (pos_q == 6'd63) begin
                sym_d      = chroma ? AC_CHROMA_TAB[SYM_EOB] : AC_LUMA_TAB[SYM_EOB];
                sym_pend_d = 1'b1;
              end
            end else begin
              zrl_n_d    = run_q[5:4];
              sym_d      = chroma ? AC_CHROMA_TAB[ac_sym] : AC_LUMA_TAB[ac_sym];
              sym_pend_d = 1'b1;
              mag_pend_d = 1'b1;
              run_d      = 6'd0;
            end
            if (pos_q == 6'd63) begin
              run_d = 6'd0;
            end
            pos_d = pos_q + 6'd1;
          end
          if (in_i.op || pos_q == 6'd0 || coef != 12'sd0 || pos_q == 6'd63) begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        chunk_valid_o = 1'b1;
        chunk_o.flush = flush_q;
        if (zrl_n_q != 2'd0) begin
          chunk_o.code = zrl_q[15:0];
          chunk_o.len  = zrl_q[20:16];
          chunk_o.last = 1'b0;
          if (chunk_ready_i) begin
            zrl_n_d = zrl_n_q - 2'd1;
          end
        end else if (sym_pend_q) begin
          chunk_o.code = sym_q[15:0];
          chunk_o.len  = sym_q[20:16];
          chunk_o.last = !mag_pend_q;
          if (chunk_ready_i) begin
            sym_pend_d = 1'b0;
            if (!mag_pend_q) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          chunk_o.code = {5'd0, mag_q};
          chunk_o.len  = {1'b0, mag_len_q};
          chunk_o.last = 1'b1;
          if (chunk_ready_i) begin
            mag_pend_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pred_q     <= '{default: '0};
      pos_q      <= '0;
      run_q      <= '0;
      zrl_n_q    <= '0;
      zrl_q      <= '0;
      sym_q      <= '0;
      sym_pend_q <= 1'b0;
      mag_q      <= '0;
      mag_len_q  <= '0;
      mag_pend_q <= 1'b0;
      flush_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      pred_q     <= pred_d;
      pos_q      <= pos_d;
      run_q      <= run_d;
      zrl_n_q    <= zrl_n_d;
      zrl_q      <= zrl_d;
      sym_q      <= sym_d;
      sym_pend_q <= sym_pend_d;
      mag_q      <= mag_d;
      mag_len_q  <= mag_len_d;
      mag_pend_q <= mag_pend_d;
      flush_q    <= flush_d;
    end
  end

endmodule

@@ rtl/jcec_queue.sv @@
`timescale 1ns / 1ps
`include "jpeg_coefficient_entropy_coder_top_defines.svh"
module jcec_queue import jcec_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  chunk_t wr_data_i,
  input  logic   wr_valid_i,
  output logic   wr_ready_o,
  output chunk_t rd_data_o,
  output logic   rd_valid_o,
  input  logic   rd_ready_i
);

  chunk_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `JCEC_ASSERT(a_queue_bound, cnt_q <= QCNT_W'(QDEPTH), "queue fill count out of range")
  `JCEC_ASSERT(a_queue_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue ptr skew")

endmodule

@@ rtl/jcec_packer.sv @@
`timescale 1ns / 1ps
`include "jpeg_coefficient_entropy_coder_top_defines.svh"
module jcec_packer import jcec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  chunk_t  chunk_i,
  input  logic    chunk_valid_i,
  output logic    chunk_ready_o,
  jcec_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_ABSORB,
    ST_EMIT,
    ST_STUFF
  } state_e;

  state_e           state_q, state_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             flush_q, flush_d;
  logic [CODE_W-1:0] code_left;
  logic [7:0]       top_byte;
  logic             out_xfer;

  assign code_left = CODE_W'(chunk_i.code << (LEN_W'(CODE_W) - chunk_i.len));
  assign top_byte  = acc_q[ACC_W-1 -: 8];
  assign out_xfer  = out_o.valid && out_o.ready;

  assign chunk_ready_o     = (state_q == ST_ABSORB);
  assign out_o.valid       = (state_q == ST_STUFF) ||
                             ((state_q == ST_EMIT) && (cnt_q >= CNT_W'(8)));
  assign out_o.out_byte    = (state_q == ST_STUFF) ? 8'h00 : top_byte;
  assign out_o.last_of_run = (state_q == ST_STUFF) ? (cnt_q < CNT_W'(8)) :
                             ((cnt_q < CNT_W'(16)) && (top_byte != BYTE_FF));

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    flush_d = flush_q;
    case (state_q)
      ST_ABSORB: begin
        if (chunk_valid_i) begin
          acc_d   = acc_q | ({code_left, {(ACC_W-CODE_W){1'b0}}} >> cnt_q);
          cnt_d   = cnt_q + CNT_W'(chunk_i.len);
          flush_d = chunk_i.flush;
          if (chunk_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (cnt_q < CNT_W'(8)) begin
          if (flush_q) begin
            acc_d   = '0;
            cnt_d   = '0;
            flush_d = 1'b0;
          end
          state_d = ST_ABSORB;
        end else if (out_xfer) begin
          acc_d = acc_q << 8;
          cnt_d = cnt_q - CNT_W'(8);
          if (top_byte == BYTE_FF) begin
            state_d = ST_STUFF;
          end
        end
      end
      ST_STUFF: begin
        if (out_xfer) begin
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ABSORB;
      acc_q   <= '0;
      cnt_q   <= '0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
    end
  end

  `JCEC_ASSERT(a_acc_bound, cnt_q <= CNT_W'(ACC_MAX), "packer bit count overflow")
  `JCEC_ASSERT(a_stuff_after_ff, (out_xfer && state_q == ST_EMIT && top_byte == BYTE_FF) |=> (out_o.valid && out_o.out_byte == 8'h00), "0xFF not followed by stuffed zero")
  `JCEC_ASSERT(a_idle_clean, (state_q == ST_ABSORB && cnt_q < CNT_W'(8)) |-> (acc_q[ACC_W-9:0] == '0), "stale bits below pending byte")

endmodule

@@ rtl/jpeg_coefficient_entropy_coder_top.sv @@
`timescale 1ns / 1ps
// JPEG baseline entropy coder. Each input transfer carries one quantized coefficient in
// zigzag order (64 per block, the first being DC) with a component tag, or a flush that
// ends the image. The output channel moves one byte of the Huffman coded stream per
// transfer, stuffed zeros after 0xFF included, and last_of_run marks the final byte
// caused by an input item; items that complete no byte cause no transfer. A front end
// takes an item, then hands on its code pieces (up to three ZRL codes, the symbol code
// and the magnitude bits) at one per cycle while the queue has room, and takes no new
// item until they are out; an AC zero inside a block has no piece. A four entry queue
// separates it from the packer, which absorbs one piece per cycle up to an item's last
// piece and then sends one byte per cycle while the output is ready; it and the output
// byte rate set the sustained throughput for bursty items. A flush pads the pending
// bits with ones, drops the fill, and the DC predictors and block position start over.
module jpeg_coefficient_entropy_coder_top import jcec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  jcec_in_if.sink    in_i,
  jcec_out_if.source out_o
);

  chunk_t front_chunk;
  logic   front_valid;
  logic   front_ready;
  chunk_t back_chunk;
  logic   back_valid;
  logic   back_ready;

  // Classifies items and breaks them into code pieces.
  jcec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .chunk_o       (front_chunk),
    .chunk_valid_o (front_valid),
    .chunk_ready_i (front_ready)
  );

  // Lets the front end run ahead while the packer waits on the output.
  jcec_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_chunk),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_chunk),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  // Packs the pieces MSB first into bytes with zero stuffing.
  jcec_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chunk_i       (back_chunk),
    .chunk_valid_i (back_valid),
    .chunk_ready_o (back_ready),
    .out_o         (out_o)
  );

endmodule
